// File: hw/rtl/tpzg_pkg.sv
// Shared types and constants for the touch pan/zoom gesture block.
// Used by tpzg_zoom and touch_pan_zoom_gesture; depends on nothing else.
package tpzg_pkg;

  localparam int PAN_BITS       = 32;
  localparam int ZOOM_BITS      = 5;
  localparam int CFG_COORD_BITS = 12;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int BUTTON_BITS    = 2;
  localparam int TAP_EVENT_BITS = 2;

  typedef enum logic [BUTTON_BITS-1:0] {
    BTN_MAP      = 2'd0,
    BTN_ZOOM_IN  = 2'd1,
    BTN_ZOOM_OUT = 2'd2,
    BTN_OTHER    = 2'd3
  } button_t;

  typedef enum logic [TAP_EVENT_BITS-1:0] {
    TAP_NONE   = 2'd0,
    TAP_SINGLE = 2'd1,
    TAP_DOUBLE = 2'd2
  } tap_event_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TAP_MAX_DURATION  = 3'd0,
    REG_TAP_MAX_MOVE      = 3'd1,
    REG_DOUBLE_TAP_WINDOW = 3'd2,
    REG_DOUBLE_TAP_RADIUS = 3'd3,
    REG_MIN_ZOOM          = 3'd4,
    REG_MAX_ZOOM          = 3'd5,
    REG_CENTER_X          = 3'd6,
    REG_CENTER_Y          = 3'd7
  } cfg_reg_t;

  // Allowed zoom range as programmed.
  typedef struct packed {
    logic [ZOOM_BITS-1:0] min_zoom;
    logic [ZOOM_BITS-1:0] max_zoom;
  } zoom_range_t;

  // Request for one zoom step: whether to step at all, and in which direction.
  typedef struct packed {
    logic step;
    logic up;
  } zoom_req_t;

endpackage

// File: hw/rtl/tpzg_zoom.sv
// One clamped zoom step with pan re-basing about a focal point.
// Depends on tpzg_pkg; purely combinational, used once by the top level.
module tpzg_zoom #(
  parameter int FOCAL_BITS = 12
) (
  input  tpzg_pkg::zoom_req_t                 req,
  input  tpzg_pkg::zoom_range_t               range,
  input  logic [tpzg_pkg::ZOOM_BITS-1:0]      zoom,
  input  logic [tpzg_pkg::PAN_BITS-1:0]       pan_x,
  input  logic [tpzg_pkg::PAN_BITS-1:0]       pan_y,
  input  logic [FOCAL_BITS-1:0]               focal_x,
  input  logic [FOCAL_BITS-1:0]               focal_y,
  output logic [tpzg_pkg::PAN_BITS-1:0]       pan_x_next,
  output logic [tpzg_pkg::PAN_BITS-1:0]       pan_y_next,
  output logic [tpzg_pkg::ZOOM_BITS-1:0]      zoom_next
);
  import tpzg_pkg::*;

  localparam int LEVEL_BITS = ZOOM_BITS + 2;
  localparam int WORLD_BITS = PAN_BITS + 2;
  localparam logic signed [LEVEL_BITS-1:0] STEP_ONE = LEVEL_BITS'(1);

  logic signed [LEVEL_BITS-1:0] cur;
  logic signed [LEVEL_BITS-1:0] lo;
  logic signed [LEVEL_BITS-1:0] hi;
  logic signed [LEVEL_BITS-1:0] target;
  logic signed [LEVEL_BITS-1:0] delta;
  logic                         changed;
  logic                         going_up;
  logic [ZOOM_BITS-1:0]         amount;

  // Shift the world coordinate under the focal point, then subtract the focal
  // point again. Zooming out floors toward minus infinity.
  function automatic logic [PAN_BITS-1:0] rebase(
    input logic [PAN_BITS-1:0]   pan,
    input logic [FOCAL_BITS-1:0] focal,
    input logic                  up,
    input logic [ZOOM_BITS-1:0]  shamt
  );
    logic signed [WORLD_BITS-1:0] world;
    logic signed [WORLD_BITS-1:0] moved;
    world = $signed({{2{pan[PAN_BITS-1]}}, pan}) + $signed(WORLD_BITS'(focal));
    moved = up ? (world <<< shamt) : (world >>> shamt);
    return moved[PAN_BITS-1:0] - PAN_BITS'(focal);
  endfunction

  always_comb begin
    cur = $signed({2'b00, zoom});
    lo  = $signed({2'b00, range.min_zoom});
    hi  = $signed({2'b00, range.max_zoom});
    target = req.up ? (cur + STEP_ONE) : (cur - STEP_ONE);
    // The upper clamp comes last, so it wins on an inverted range.
    if (target < lo) begin
      target = lo;
    end
    if (target > hi) begin
      target = hi;
    end
    changed  = req.step && (target != cur);
    going_up = target > cur;
    delta    = going_up ? (target - cur) : (cur - target);
    amount   = delta[ZOOM_BITS-1:0];
  end

  assign pan_x_next = changed ? rebase(pan_x, focal_x, going_up, amount) : pan_x;
  assign pan_y_next = changed ? rebase(pan_y, focal_y, going_up, amount) : pan_y;
  assign zoom_next  = changed ? target[ZOOM_BITS-1:0] : zoom;

endmodule

// File: hw/rtl/touch_pan_zoom_gesture.sv
// Top level of the touch pan/zoom gesture recognizer.
// Depends on tpzg_pkg and tpzg_zoom.
//
// The block takes one touch poll per transfer and returns one result per poll:
// the pan offset, zoom level and drag state after that poll, plus a tap event
// code in m_tuser. A one-finger drag on the map pans the view, a press that
// starts on a zoom button steps the zoom about the programmed screen center,
// and a quick second tap near the first one zooms in about its touch-down
// point. The gesture state and the result are both updated at the edge that
// accepts the poll, so the result is registered for the master side at that
// edge. One poll per cycle is sustained while s_tready stays high, since each
// poll depends on the state the previous poll left and that state is updated
// at the edge that accepts the previous poll. The result side has an output
// register plus one skid entry, so a poll is still accepted while a result
// waits; s_tready falls only when both hold results. Distances are compared
// as exact squares; the squares of the move and radius limits are formed
// when those registers are written. All state comes out of reset at once,
// with no clearing pass. Configuration may be written only while no results
// are outstanding.
module touch_pan_zoom_gesture #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 48
) (
  input  logic clk,
  input  logic rst,
  // Touch polls.
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // From bit 0 up: pressed, touch_x, touch_y, time_us, zero fill.
  input  logic [((1 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // button_hit.
  input  logic [tpzg_pkg::BUTTON_BITS-1:0]              s_tuser,
  // Results.
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // From bit 0 up: pan_x, pan_y, zoom_level, is_dragging, zero fill.
  output logic [((2*tpzg_pkg::PAN_BITS + tpzg_pkg::ZOOM_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // tap_event.
  output logic [tpzg_pkg::TAP_EVENT_BITS-1:0]           m_tuser,
  // Configuration writes.
  input  logic                                          cfg_wen,
  input  logic [tpzg_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [tpzg_pkg::CFG_DATA_BITS-1:0]            cfg_data
);
  import tpzg_pkg::*;

  localparam int IN_DATA_BITS   = ((1 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((2*PAN_BITS + ZOOM_BITS + 1 + 7) / 8) * 8;
  localparam int SQ_BITS        = 2*COORD_BITS + 1;
  localparam int PROD_BITS      = 2*COORD_BITS + 2;
  localparam int LIMIT_SQ_BITS  = 2*CFG_COORD_BITS;
  localparam int CMP_BITS       = (SQ_BITS > LIMIT_SQ_BITS) ? SQ_BITS : LIMIT_SQ_BITS;
  localparam int FOCAL_BITS     = (COORD_BITS > CFG_COORD_BITS) ? COORD_BITS : CFG_COORD_BITS;
  localparam int X_LSB          = 1;
  localparam int Y_LSB          = X_LSB + COORD_BITS;
  localparam int T_LSB          = Y_LSB + COORD_BITS;

  // Configuration registers; the two distance limits are kept squared.
  logic [CFG_DATA_BITS-1:0]  tap_max_duration;
  logic [LIMIT_SQ_BITS-1:0]  tap_move_sq;
  logic [CFG_DATA_BITS-1:0]  double_tap_window;
  logic [LIMIT_SQ_BITS-1:0]  tap_radius_sq;
  zoom_range_t               zrange;
  logic [CFG_COORD_BITS-1:0] center_x;
  logic [CFG_COORD_BITS-1:0] center_y;
  logic [LIMIT_SQ_BITS-1:0]  cfg_sq;

  // Gesture state.
  logic [PAN_BITS-1:0]   pan_x, pan_x_next;
  logic [PAN_BITS-1:0]   pan_y, pan_y_next;
  logic [ZOOM_BITS-1:0]  zoom, zoom_next;
  logic                  touching, touching_next;
  logic                  dragging, dragging_next;
  logic                  press_on_button, press_on_button_next;
  logic [COORD_BITS-1:0] prev_x, prev_x_next;
  logic [COORD_BITS-1:0] prev_y, prev_y_next;
  logic [TIME_BITS-1:0]  down_time, down_time_next;
  logic [COORD_BITS-1:0] down_x, down_x_next;
  logic [COORD_BITS-1:0] down_y, down_y_next;
  logic [SQ_BITS-1:0]    max_move_sq, max_move_sq_next;
  logic [SQ_BITS-1:0]    tap_gap_sq, tap_gap_sq_next;
  logic                  have_prev_tap, have_prev_tap_next;
  logic [TIME_BITS-1:0]  prev_tap_time, prev_tap_time_next;
  logic [COORD_BITS-1:0] prev_tap_x, prev_tap_x_next;
  logic [COORD_BITS-1:0] prev_tap_y, prev_tap_y_next;

  // Output register and skid entry.
  logic                      out_valid;
  logic [OUT_DATA_BITS-1:0]  out_data;
  logic [TAP_EVENT_BITS-1:0] out_user;
  logic                      skid_valid;
  logic [OUT_DATA_BITS-1:0]  skid_data;
  logic [TAP_EVENT_BITS-1:0] skid_user;

  // Poll fields and per-poll logic.
  logic                   s_fire;
  logic                   m_fire;
  logic                   pressed;
  logic [COORD_BITS-1:0]  touch_x;
  logic [COORD_BITS-1:0]  touch_y;
  logic [TIME_BITS-1:0]   time_us;
  button_t                button_hit;
  tap_event_t             tap_event;
  logic [COORD_BITS-1:0]  ref_x;
  logic [COORD_BITS-1:0]  ref_y;
  logic signed [COORD_BITS:0]     dx;
  logic signed [COORD_BITS:0]     dy;
  logic signed [PROD_BITS-1:0]    dx_sq;
  logic signed [PROD_BITS-1:0]    dy_sq;
  logic [SQ_BITS-1:0]     dist_sq;
  logic [TIME_BITS-1:0]   press_time;
  logic [TIME_BITS-1:0]   since_tap;
  zoom_req_t              zreq;
  logic [FOCAL_BITS-1:0]  focal_x;
  logic [FOCAL_BITS-1:0]  focal_y;
  logic [PAN_BITS-1:0]    zpan_x;
  logic [PAN_BITS-1:0]    zpan_y;
  logic [ZOOM_BITS-1:0]   zzoom;
  logic [PAN_BITS-1:0]    drag_pan_x;
  logic [PAN_BITS-1:0]    drag_pan_y;
  logic [OUT_DATA_BITS-1:0] res_data;

  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = out_valid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  assign pressed    = s_tdata[0];
  assign touch_x    = s_tdata[X_LSB +: COORD_BITS];
  assign touch_y    = s_tdata[Y_LSB +: COORD_BITS];
  assign time_us    = s_tdata[T_LSB +: TIME_BITS];
  assign button_hit = button_t'(s_tuser);

  // Squared limit for whichever distance register is being written.
  assign cfg_sq = LIMIT_SQ_BITS'(cfg_data[CFG_COORD_BITS-1:0]) *
                  LIMIT_SQ_BITS'(cfg_data[CFG_COORD_BITS-1:0]);

  // One shared squared-distance unit. While held it measures the drift from
  // touch-down; on touch-down it measures the gap to the last recorded tap,
  // which cannot change before this press is released.
  assign ref_x   = touching ? down_x : prev_tap_x;
  assign ref_y   = touching ? down_y : prev_tap_y;
  assign dx      = $signed({1'b0, touch_x}) - $signed({1'b0, ref_x});
  assign dy      = $signed({1'b0, touch_y}) - $signed({1'b0, ref_y});
  assign dx_sq   = PROD_BITS'(dx) * PROD_BITS'(dx);
  assign dy_sq   = PROD_BITS'(dy) * PROD_BITS'(dy);
  assign dist_sq = SQ_BITS'(dx_sq[2*COORD_BITS-1:0]) + SQ_BITS'(dy_sq[2*COORD_BITS-1:0]);

  assign press_time = time_us - down_time;
  assign since_tap  = time_us - prev_tap_time;

  // Drag pans by the finger movement since the previous poll, wrapping at 32 bits.
  assign drag_pan_x = pan_x - PAN_BITS'(touch_x) + PAN_BITS'(prev_x);
  assign drag_pan_y = pan_y - PAN_BITS'(touch_y) + PAN_BITS'(prev_y);

  tpzg_zoom #(
    .FOCAL_BITS (FOCAL_BITS)
  ) u_zoom (
    .req        (zreq),
    .range      (zrange),
    .zoom       (zoom),
    .pan_x      (pan_x),
    .pan_y      (pan_y),
    .focal_x    (focal_x),
    .focal_y    (focal_y),
    .pan_x_next (zpan_x),
    .pan_y_next (zpan_y),
    .zoom_next  (zzoom)
  );

  always_comb begin
    touching_next        = pressed;
    dragging_next        = dragging;
    press_on_button_next = press_on_button;
    prev_x_next          = prev_x;
    prev_y_next          = prev_y;
    down_time_next       = down_time;
    down_x_next          = down_x;
    down_y_next          = down_y;
    max_move_sq_next     = max_move_sq;
    tap_gap_sq_next      = tap_gap_sq;
    have_prev_tap_next   = have_prev_tap;
    prev_tap_time_next   = prev_tap_time;
    prev_tap_x_next      = prev_tap_x;
    prev_tap_y_next      = prev_tap_y;
    pan_x_next           = pan_x;
    pan_y_next           = pan_y;
    tap_event            = TAP_NONE;
    zreq.step            = 1'b0;
    zreq.up              = 1'b1;
    focal_x              = FOCAL_BITS'(center_x);
    focal_y              = FOCAL_BITS'(center_y);

    if (pressed) begin
      if (!touching) begin
        // Touch-down: the button code counts only on this poll.
        down_time_next   = time_us;
        down_x_next      = touch_x;
        down_y_next      = touch_y;
        max_move_sq_next = '0;
        tap_gap_sq_next  = dist_sq;
        dragging_next    = 1'b0;
        case (button_hit)
          BTN_ZOOM_IN: begin
            zreq.step            = 1'b1;
            zreq.up              = 1'b1;
            press_on_button_next = 1'b1;
          end
          BTN_ZOOM_OUT: begin
            zreq.step            = 1'b1;
            zreq.up              = 1'b0;
            press_on_button_next = 1'b1;
          end
          BTN_OTHER: begin
            press_on_button_next = 1'b1;
          end
          default: begin
            press_on_button_next = 1'b0;
          end
        endcase
      end else if (!press_on_button) begin
        // The first held poll only starts the drag; panning follows after.
        if (dragging) begin
          pan_x_next = drag_pan_x;
          pan_y_next = drag_pan_y;
        end
        dragging_next = 1'b1;
        if (dist_sq > max_move_sq) begin
          max_move_sq_next = dist_sq;
        end
      end
      prev_x_next = touch_x;
      prev_y_next = touch_y;
    end else begin
      if (touching && !press_on_button) begin
        if (press_time < TIME_BITS'(tap_max_duration) &&
            CMP_BITS'(max_move_sq) < CMP_BITS'(tap_move_sq)) begin
          if (have_prev_tap && since_tap < TIME_BITS'(double_tap_window) &&
              CMP_BITS'(tap_gap_sq) < CMP_BITS'(tap_radius_sq)) begin
            zreq.step          = 1'b1;
            zreq.up            = 1'b1;
            focal_x            = FOCAL_BITS'(down_x);
            focal_y            = FOCAL_BITS'(down_y);
            have_prev_tap_next = 1'b0;
            tap_event          = TAP_DOUBLE;
          end else begin
            have_prev_tap_next = 1'b1;
            prev_tap_time_next = time_us;
            prev_tap_x_next    = down_x;
            prev_tap_y_next    = down_y;
            tap_event          = TAP_SINGLE;
          end
        end
      end
      dragging_next        = 1'b0;
      press_on_button_next = 1'b0;
    end

    // A zoom step never coincides with a drag pan on the same poll.
    if (zreq.step) begin
      pan_x_next = zpan_x;
      pan_y_next = zpan_y;
    end
  end

  assign zoom_next = zzoom;
  assign res_data  = OUT_DATA_BITS'({dragging_next, zoom_next, pan_y_next, pan_x_next});

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_max_duration  <= CFG_DATA_BITS'(300000);
      tap_move_sq       <= LIMIT_SQ_BITS'(400);
      double_tap_window <= CFG_DATA_BITS'(400000);
      tap_radius_sq     <= LIMIT_SQ_BITS'(1600);
      zrange.min_zoom   <= ZOOM_BITS'(0);
      zrange.max_zoom   <= ZOOM_BITS'(19);
      center_x          <= CFG_COORD_BITS'(360);
      center_y          <= CFG_COORD_BITS'(640);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAP_MAX_DURATION:  tap_max_duration  <= cfg_data;
        REG_TAP_MAX_MOVE:      tap_move_sq       <= cfg_sq;
        REG_DOUBLE_TAP_WINDOW: double_tap_window <= cfg_data;
        REG_DOUBLE_TAP_RADIUS: tap_radius_sq     <= cfg_sq;
        REG_MIN_ZOOM:          zrange.min_zoom   <= cfg_data[ZOOM_BITS-1:0];
        REG_MAX_ZOOM:          zrange.max_zoom   <= cfg_data[ZOOM_BITS-1:0];
        REG_CENTER_X:          center_x          <= cfg_data[CFG_COORD_BITS-1:0];
        REG_CENTER_Y:          center_y          <= cfg_data[CFG_COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Gesture state, updated by every accepted poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_x           <= '0;
      pan_y           <= '0;
      zoom            <= '0;
      touching        <= 1'b0;
      dragging        <= 1'b0;
      press_on_button <= 1'b0;
      prev_x          <= '0;
      prev_y          <= '0;
      down_time       <= '0;
      down_x          <= '0;
      down_y          <= '0;
      max_move_sq     <= '0;
      tap_gap_sq      <= '0;
      have_prev_tap   <= 1'b0;
      prev_tap_time   <= '0;
      prev_tap_x      <= '0;
      prev_tap_y      <= '0;
    end else if (s_fire) begin
      pan_x           <= pan_x_next;
      pan_y           <= pan_y_next;
      zoom            <= zoom_next;
      touching        <= touching_next;
      dragging        <= dragging_next;
      press_on_button <= press_on_button_next;
      prev_x          <= prev_x_next;
      prev_y          <= prev_y_next;
      down_time       <= down_time_next;
      down_x          <= down_x_next;
      down_y          <= down_y_next;
      max_move_sq     <= max_move_sq_next;
      tap_gap_sq      <= tap_gap_sq_next;
      have_prev_tap   <= have_prev_tap_next;
      prev_tap_time   <= prev_tap_time_next;
      prev_tap_x      <= prev_tap_x_next;
      prev_tap_y      <= prev_tap_y_next;
    end
  end

  // Result buffer control: the skid entry fills only when the output register
  // is held by a result that is not taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (s_fire) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_fire) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end
    end else if (s_fire) begin
      if (out_valid && !m_tready) begin
        skid_data <= res_data;
        skid_user <= tap_event;
      end else begin
        out_data <= res_data;
        out_user <= tap_event;
      end
    end
  end

`ifndef SYNTHESIS
  // The skid entry is only ever used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // A drag exists only during a held press that did not start on a control.
  a_drag_needs_press: assert property (@(posedge clk) disable iff (rst)
    dragging |-> (touching && !press_on_button))
    else $error("drag state set outside a map press");

  // A recognized double tap consumes the pending tap.
  a_double_clears_tap: assert property (@(posedge clk) disable iff (rst)
    (s_fire && tap_event == TAP_DOUBLE) |=> !have_prev_tap)
    else $error("pending tap survived a double tap");

  // A single tap always leaves a pending tap at the touch-down point.
  a_single_records_tap: assert property (@(posedge clk) disable iff (rst)
    (s_fire && tap_event == TAP_SINGLE) |=>
      (have_prev_tap && prev_tap_x == $past(down_x) && prev_tap_y == $past(down_y)))
    else $error("single tap not recorded");
`endif

endmodule

// File: dv/touch_pan_zoom_gesture_tb.sv
// Self-checking testbench for touch_pan_zoom_gesture: drives touch polls and
// register writes, and checks every result against a gesture model kept here.
// Depends on tpzg_pkg and the RTL of the block; reads no files.
module touch_pan_zoom_gesture_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpzg_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int TIME_BITS  = 48;
  localparam int POLL_BITS  = ((1 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int VIEW_BITS  = ((2*PAN_BITS + ZOOM_BITS + 1 + 7) / 8) * 8;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // One touch poll as the sender sees it.
  typedef struct {
    bit                  pressed;
    bit [COORD_BITS-1:0] x;
    bit [COORD_BITS-1:0] y;
    bit [TIME_BITS-1:0]  t;
    button_t             button;
  } poll_t;

  // One result: the view after a poll plus the tap code.
  typedef struct {
    bit [PAN_BITS-1:0]  pan_x;
    bit [PAN_BITS-1:0]  pan_y;
    bit [ZOOM_BITS-1:0] zoom;
    bit                 dragging;
    tap_event_t         tap;
  } view_t;

  // Gesture model with its own copy of the registers and state, plus the queue
  // of views that the block still owes us.
  class gesture_scoreboard;
    bit [31:0]           tap_dur_lim, dtap_window;
    bit [COORD_BITS-1:0] move_lim, dtap_radius, focus_x, focus_y;
    bit [ZOOM_BITS-1:0]  zoom_lo, zoom_hi;

    bit [PAN_BITS-1:0]   pan_x, pan_y;
    bit [ZOOM_BITS-1:0]  zoom;
    bit                  was_down, dragging, on_button, tap_pending;
    bit [COORD_BITS-1:0] last_x, last_y, down_x, down_y, tap_x, tap_y;
    bit [31:0]           peak_move_sq;
    bit [TIME_BITS-1:0]  down_t, tap_t;

    view_t expected_views[$];
    int    errors, checked, singles, doubles, drag_polls, zoom_moves;

    function new();
      tap_dur_lim = 300000; move_lim = 20; dtap_window = 400000; dtap_radius = 40;
      zoom_lo = 0; zoom_hi = 19; focus_x = 360; focus_y = 640;
      pan_x = 0; pan_y = 0; zoom = 0;
      was_down = 0; dragging = 0; on_button = 0; tap_pending = 0;
      last_x = 0; last_y = 0; down_x = 0; down_y = 0; tap_x = 0; tap_y = 0;
      peak_move_sq = 0; down_t = 0; tap_t = 0;
      errors = 0; checked = 0; singles = 0; doubles = 0; drag_polls = 0; zoom_moves = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_TAP_MAX_DURATION:  tap_dur_lim = v;
        REG_TAP_MAX_MOVE:      move_lim    = v[COORD_BITS-1:0];
        REG_DOUBLE_TAP_WINDOW: dtap_window = v;
        REG_DOUBLE_TAP_RADIUS: dtap_radius = v[COORD_BITS-1:0];
        REG_MIN_ZOOM:          zoom_lo     = v[ZOOM_BITS-1:0];
        REG_MAX_ZOOM:          zoom_hi     = v[ZOOM_BITS-1:0];
        REG_CENTER_X:          focus_x     = v[COORD_BITS-1:0];
        REG_CENTER_Y:          focus_y     = v[COORD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    function bit [31:0] squared_dist(bit [COORD_BITS-1:0] ax, bit [COORD_BITS-1:0] ay,
                                     bit [COORD_BITS-1:0] bx, bit [COORD_BITS-1:0] by);
      int dx, dy;
      dx = int'(ax) - int'(bx);
      dy = int'(ay) - int'(by);
      return dx*dx + dy*dy;
    endfunction

    // Keeps the world point under the focal pixel fixed across a zoom change.
    // Zooming out is a floor division, so negative pans round toward minus
    // infinity.
    function bit [PAN_BITS-1:0] rebase(bit [PAN_BITS-1:0] pan, bit [COORD_BITS-1:0] focal,
                                       bit up, int amount);
      longint world, moved;
      world = longint'($signed(pan)) + longint'(focal);
      moved = up ? (world <<< amount) : (world >>> amount);
      return PAN_BITS'(moved - longint'(focal));
    endfunction

    function void step_zoom(bit [COORD_BITS-1:0] fx, bit [COORD_BITS-1:0] fy, int delta);
      int target, held;
      bit up;
      held   = int'(zoom);
      target = held + delta;
      // The upper clamp comes last, so it wins for an inverted range.
      if (target < int'(zoom_lo)) target = int'(zoom_lo);
      if (target > int'(zoom_hi)) target = int'(zoom_hi);
      if (target == held) return;
      up    = target > held;
      pan_x = rebase(pan_x, fx, up, up ? target - held : held - target);
      pan_y = rebase(pan_y, fy, up, up ? target - held : held - target);
      zoom  = ZOOM_BITS'(target);
      zoom_moves++;
    endfunction

    function void note_poll(poll_t p);
      view_t      v;
      tap_event_t ev;
      bit [31:0]  d2;
      bit [TIME_BITS-1:0] held_for, since_tap;
      ev = TAP_NONE;
      if (p.pressed) begin
        if (!was_down) begin
          // Touch-down: only here does the button code matter.
          down_t = p.t; down_x = p.x; down_y = p.y;
          peak_move_sq = 0;
          dragging = 0;
          case (p.button)
            BTN_ZOOM_IN: begin
              step_zoom(focus_x, focus_y, 1);
              on_button = 1;
            end
            BTN_ZOOM_OUT: begin
              step_zoom(focus_x, focus_y, -1);
              on_button = 1;
            end
            default: on_button = (p.button == BTN_OTHER);
          endcase
        end else if (!on_button) begin
          // The first held poll only starts the drag; panning follows later.
          if (dragging) begin
            pan_x = pan_x - PAN_BITS'(p.x) + PAN_BITS'(last_x);
            pan_y = pan_y - PAN_BITS'(p.y) + PAN_BITS'(last_y);
          end
          dragging = 1;
          d2 = squared_dist(p.x, p.y, down_x, down_y);
          if (d2 > peak_move_sq) peak_move_sq = d2;
        end
        last_x = p.x;
        last_y = p.y;
      end else begin
        if (was_down && !on_button) begin
          held_for = p.t - down_t;
          if (longint'(held_for) < longint'(tap_dur_lim) &&
              longint'(peak_move_sq) < longint'(move_lim) * longint'(move_lim)) begin
            since_tap = p.t - tap_t;
            if (tap_pending && longint'(since_tap) < longint'(dtap_window) &&
                longint'(squared_dist(down_x, down_y, tap_x, tap_y)) <
                longint'(dtap_radius) * longint'(dtap_radius)) begin
              step_zoom(down_x, down_y, 1);
              tap_pending = 0;
              ev = TAP_DOUBLE;
            end else begin
              tap_pending = 1;
              tap_t = p.t; tap_x = down_x; tap_y = down_y;
              ev = TAP_SINGLE;
            end
          end
        end
        dragging  = 0;
        on_button = 0;
      end
      was_down = p.pressed;

      v.pan_x = pan_x; v.pan_y = pan_y; v.zoom = zoom;
      v.dragging = dragging; v.tap = ev;
      expected_views.push_back(v);
    endfunction

    function void check_view(view_t got);
      view_t want;
      if (expected_views.size() == 0) begin
        $error("result transfer with no poll outstanding");
        errors++;
        return;
      end
      want = expected_views.pop_front();
      checked++;
      if (want.tap == TAP_SINGLE) singles++;
      if (want.tap == TAP_DOUBLE) doubles++;
      if (want.dragging) drag_polls++;
      if (got.pan_x !== want.pan_x) begin
        $error("pan_x expected %0d got %0d", $signed(want.pan_x), $signed(got.pan_x));
        errors++;
      end
      if (got.pan_y !== want.pan_y) begin
        $error("pan_y expected %0d got %0d", $signed(want.pan_y), $signed(got.pan_y));
        errors++;
      end
      if (got.zoom !== want.zoom) begin
        $error("zoom_level expected %0d got %0d", want.zoom, got.zoom);
        errors++;
      end
      if (got.dragging !== want.dragging) begin
        $error("is_dragging expected %0d got %0d", want.dragging, got.dragging);
        errors++;
      end
      if (got.tap !== want.tap) begin
        $error("tap_event expected %0d got %0d", want.tap, got.tap);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  // From bit 0 up: pressed, touch_x, touch_y, time_us, zero fill.
  logic [POLL_BITS-1:0]       s_tdata;
  // button_hit.
  logic [BUTTON_BITS-1:0]     s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  // From bit 0 up: pan_x, pan_y, zoom_level, is_dragging, zero fill.
  logic [VIEW_BITS-1:0]       m_tdata;
  // tap_event.
  logic [TAP_EVENT_BITS-1:0]  m_tuser;
  logic                       cfg_wen;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;

  gesture_scoreboard board = new();

  // When set, neither side inserts idle cycles.
  bit steady_flow = 0;
  // Running poll clock in microseconds; wraps like the block's timestamps.
  bit [TIME_BITS-1:0] now_us = 0;
  int polls_sent = 0;

  touch_pan_zoom_gesture #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: sample transfers at the rising edge, change tready at the
  // falling edge so the two never race.
  initial begin
    view_t got;
    m_tready <= 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.pan_x    = m_tdata[PAN_BITS-1:0];
        got.pan_y    = m_tdata[2*PAN_BITS-1:PAN_BITS];
        got.zoom     = m_tdata[2*PAN_BITS +: ZOOM_BITS];
        got.dragging = m_tdata[2*PAN_BITS + ZOOM_BITS];
        got.tap      = tap_event_t'(m_tuser);
        board.check_view(got);
      end
      @(negedge clk);
      m_tready <= steady_flow || ($urandom_range(99) >= 32);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // tvalid stays high across back-to-back polls, so it only gets one update
  // per time step.
  task automatic send_poll(bit pressed, int x, int y, bit [TIME_BITS-1:0] t, button_t b);
    poll_t p;
    p.pressed = pressed;
    p.x = COORD_BITS'(x);
    p.y = COORD_BITS'(y);
    p.t = t;
    p.button = b;
    while (!steady_flow && $urandom_range(99) < 32) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {{(POLL_BITS - 1 - 2*COORD_BITS - TIME_BITS){1'b0}}, p.t, p.y, p.x, p.pressed};
    s_tuser  <= p.button;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_poll(p);
    polls_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every poll has its result back. The block
  // answers every poll, so an empty queue means it is idle.
  task automatic drain();
    s_tvalid <= 0;
    while (board.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Writes all eight registers, in index order, while the block is idle.
  task automatic program_regs(bit [31:0] dur, bit [31:0] mv, bit [31:0] win, bit [31:0] rad,
                              bit [31:0] zlo, bit [31:0] zhi, bit [31:0] cx, bit [31:0] cy);
    bit [31:0] vals [8];
    vals = '{dur, mv, win, rad, zlo, zhi, cx, cy};
    for (int i = 0; i < 8; i++) begin
      cfg_wen   <= 1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      board.set_reg(cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wen <= 0;
  endtask

  function automatic int on_screen(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Advances the poll clock. Mostly short steps that keep gestures inside the
  // tap windows, sometimes long ones that break them, and now and then a jump
  // to just below the wrap point.
  function automatic bit [TIME_BITS-1:0] tick();
    int r;
    r = $urandom_range(99);
    if (r < 2)
      now_us = {TIME_BITS{1'b1}} - $urandom_range(60000);
    else if (r < 8)
      now_us += $urandom_range(100000, 900000);
    else
      now_us += $urandom_range(200, 40000);
    return now_us;
  endfunction

  function automatic button_t any_button();
    return button_t'($urandom_range(3));
  endfunction

  // A short, nearly still press on the map. The button code of held polls
  // and the position of the release poll do not matter to the block.
  task automatic tap_at(int x, int y);
    int n;
    send_poll(1, x, y, tick(), BTN_MAP);
    n = $urandom_range(0, 3);
    repeat (n) begin
      x = on_screen(x + $urandom_range(0, 6) - 3);
      y = on_screen(y + $urandom_range(0, 6) - 3);
      send_poll(1, x, y, tick(), any_button());
    end
    send_poll(0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), tick(), any_button());
  endtask

  task automatic drag_from(int x, int y);
    int n;
    send_poll(1, x, y, tick(), BTN_MAP);
    n = $urandom_range(2, 12);
    repeat (n) begin
      x = on_screen(x + $urandom_range(0, 600) - 300);
      y = on_screen(y + $urandom_range(0, 600) - 300);
      send_poll(1, x, y, tick(), any_button());
    end
    send_poll(0, x, y, tick(), any_button());
  endtask

  // Press that starts on a zoom button or another control, held a little.
  task automatic button_press();
    int n;
    send_poll(1, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), tick(),
              button_t'($urandom_range(1, 3)));
    n = $urandom_range(0, 3);
    repeat (n)
      send_poll(1, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), tick(), any_button());
    send_poll(0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), tick(), any_button());
  endtask

  // Mostly well-formed gestures with random content; the rest is idle polls
  // and raw noise that breaks gestures apart and sweeps the full timestamp.
  task automatic run_gestures(int count);
    int start, kind, x, y, n;
    start = polls_sent;
    while (polls_sent - start < count) begin
      kind = $urandom_range(99);
      x = $urandom_range(COORD_MAX);
      y = $urandom_range(COORD_MAX);
      if (kind < 18) begin
        tap_at(x, y);
      end else if (kind < 36) begin
        // Double tap: the second one lands near the first.
        tap_at(x, y);
        if ($urandom_range(1)) send_poll(0, x, y, tick(), BTN_MAP);
        tap_at(on_screen(x + $urandom_range(0, 60) - 30), on_screen(y + $urandom_range(0, 60) - 30));
      end else if (kind < 58) begin
        drag_from(x, y);
      end else if (kind < 76) begin
        button_press();
      end else if (kind < 86) begin
        n = $urandom_range(1, 3);
        repeat (n) send_poll(0, x, y, tick(), any_button());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n)
          send_poll(1'($urandom_range(1)), $urandom_range(COORD_MAX),
                    $urandom_range(COORD_MAX), TIME_BITS'({$urandom(), $urandom()}),
                    any_button());
      end
    end
  endtask

  initial begin
    int guard;
    rst       <= 1;
    s_tvalid  <= 0;
    s_tdata   <= '0;
    s_tuser   <= BTN_MAP;
    cfg_wen   <= 0;
    cfg_index <= REG_TAP_MAX_DURATION;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed part at reset values. Zoom-out at the floor changes nothing,
    // the held button code is ignored, another control swallows its press,
    // the first held poll of a drag does not pan, and a tap spans the wrap
    // of the timestamp before a second tap zooms in about its own point.
    send_poll(0, 0, 0, 48'd100, BTN_MAP);
    send_poll(1, 500, 500, 48'd1000, BTN_ZOOM_OUT);
    send_poll(1, 510, 500, 48'd2000, BTN_ZOOM_IN);
    send_poll(0, 510, 500, 48'd3000, BTN_MAP);
    send_poll(1, 700, 900, 48'd4000, BTN_ZOOM_IN);
    send_poll(0, 700, 900, 48'd5000, BTN_OTHER);
    send_poll(1, COORD_MAX, COORD_MAX, 48'd6000, BTN_OTHER);
    send_poll(1, 0, 0, 48'd7000, BTN_MAP);
    send_poll(0, 0, 0, 48'd8000, BTN_MAP);
    send_poll(1, 100, 200, 48'd9000, BTN_MAP);
    send_poll(1, 150, 260, 48'd10000, BTN_ZOOM_IN);
    send_poll(1, COORD_MAX, 0, 48'd11000, BTN_ZOOM_OUT);
    send_poll(1, 0, COORD_MAX, 48'd12000, BTN_OTHER);
    send_poll(0, 0, COORD_MAX, 48'd2000000, BTN_MAP);
    send_poll(1, 1000, 1000, {TIME_BITS{1'b1}} - 48'd1999, BTN_MAP);
    send_poll(0, 1000, 1000, 48'd3000, BTN_MAP);
    send_poll(1, 1010, 1005, 48'd10000, BTN_MAP);
    send_poll(0, 1010, 1005, 48'd20000, BTN_MAP);
    send_poll(1, 360, 640, 48'd30000, BTN_ZOOM_OUT);
    send_poll(0, 360, 640, 48'd40000, BTN_MAP);
    send_poll(1, 360, 640, 48'd50000, BTN_ZOOM_OUT);
    send_poll(0, 360, 640, 48'd60000, BTN_MAP);
    now_us = 48'd100000;
    drain();

    // Moderate settings, with a stretch of unbroken flow and a pause in the
    // middle where the sender waits for every result.
    program_regs($urandom_range(150000, 500000), $urandom_range(5, 60),
                 $urandom_range(250000, 800000), $urandom_range(10, 100),
                 $urandom_range(0, 3), $urandom_range(15, 31),
                 $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    run_gestures(70);
    drain();
    steady_flow = 1;
    run_gestures(70);
    steady_flow = 0;
    run_gestures(70);
    drain();

    // Upper extremes: every short press is a tap and zoom may climb to the top.
    program_regs(32'hFFFF_FFFF, COORD_MAX, 32'hFFFF_FFFF, COORD_MAX, 0, 31,
                 COORD_MAX, COORD_MAX);
    repeat (6) begin
      send_poll(1, 10, 10, tick(), BTN_ZOOM_IN);
      send_poll(0, 10, 10, tick(), BTN_MAP);
    end
    run_gestures(90);
    drain();

    // Lower extremes: no tap qualifies, and the inverted zoom range forces
    // every step onto the upper limit, a jump of several levels at once.
    program_regs(0, 0, 0, 0, 20, 5, 0, 0);
    run_gestures(60);
    drain();

    // Narrow zoom range with ordinary tap limits.
    program_regs(400000, 30, 600000, 60, 2, 6, $urandom_range(COORD_MAX),
                 $urandom_range(COORD_MAX));
    run_gestures(60);

    s_tvalid <= 0;
    guard = 0;
    while (board.pending() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (5) @(negedge clk);
    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
      board.errors++;
    end

    $display("Sent %0d polls across five register settings; checked %0d results.",
             polls_sent, board.checked);
    $display("Seen: %0d single taps, %0d double taps, %0d drag polls, %0d zoom changes.",
             board.singles, board.doubles, board.drag_polls, board.zoom_moves);
    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
